/* rtl/qat_pkg.sv */
package qat_pkg;

    localparam logic [7:0] CharSp  = 8'h20;
    localparam logic [7:0] CharTab = 8'h09;
    localparam logic [7:0] CharLf  = 8'h0A;
    localparam logic [7:0] CharCr  = 8'h0D;
    localparam logic [7:0] CharDq  = 8'h22;
    localparam logic [7:0] CharSq  = 8'h27;
    localparam logic [7:0] CharBs  = 8'h5C;

    localparam logic [1:0] QuoteNone   = 2'd0;
    localparam logic [1:0] QuoteDouble = 2'd1;
    localparam logic [1:0] QuoteSingle = 2'd2;

    // Result queue must hold at least the two results of one request.
    localparam int ResDepth = 4;
    localparam int ResPtrW  = $clog2(ResDepth);
    localparam int ResCntW  = $clog2(ResDepth + 1);

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       in_token;
        logic [1:0] quote_kind;
        logic       escape_pending;
    } tok_state_t;

endpackage

/* rtl/qat_decode.sv */
module qat_decode (
    input  logic [7:0]          in_char,
    input  logic                in_end,
    input  qat_pkg::tok_state_t state_cur,
    output qat_pkg::tok_state_t state_nxt,
    output logic [1:0]          res_count,
    output qat_pkg::result_t    res0,
    output qat_pkg::result_t    res1
);

    always_comb
    begin
        logic       is_ws;
        logic       is_quote;
        logic       skip;
        logic [1:0] qc;
        logic [1:0] q;
        logic       e;
        logic       emit_bs;
        logic       emit_c;

        is_ws = (in_char == qat_pkg::CharSp) || (in_char == qat_pkg::CharTab) ||
                (in_char == qat_pkg::CharLf) || (in_char == qat_pkg::CharCr);
        is_quote = (in_char == qat_pkg::CharDq) || (in_char == qat_pkg::CharSq);
        qc = (in_char == qat_pkg::CharDq) ? qat_pkg::QuoteDouble :
             (in_char == qat_pkg::CharSq) ? qat_pkg::QuoteSingle : qat_pkg::QuoteNone;
        skip = 1'b0;
        emit_bs = 1'b0;
        emit_c = 1'b0;
        q = state_cur.quote_kind;
        e = state_cur.escape_pending;
        state_nxt = state_cur;
        res0 = '0;
        res1 = '0;
        res_count = 2'd0;

        if (!state_cur.in_token)
        begin
            if (in_end || is_ws)
            begin
                skip = 1'b1;
            end
            else
            begin
                state_nxt.in_token = 1'b1;
                q = qat_pkg::QuoteNone;
                e = 1'b0;
            end
        end
        else if (in_end || (in_char == qat_pkg::CharTab) || (in_char == qat_pkg::CharLf) ||
                 (in_char == qat_pkg::CharCr) ||
                 ((in_char == qat_pkg::CharSp) && (q == qat_pkg::QuoteNone) && !e))
        begin
            skip = 1'b1;
            state_nxt = '0;
            res0.token_end = 1'b1;
            res0.last = 1'b1;
            res_count = 2'd1;
        end

        if (!skip)
        begin
            if (is_quote)
            begin
                if (q == qc)
                begin
                    if (e)
                    begin
                        emit_c = 1'b1;
                        e = 1'b0;
                    end
                    else
                    begin
                        q = qat_pkg::QuoteNone;
                    end
                end
                else if ((q == qat_pkg::QuoteNone) && !e)
                begin
                    q = qc;
                end
                else
                begin
                    e = 1'b0;
                    emit_c = 1'b1;
                end
            end
            else if (in_char == qat_pkg::CharBs)
            begin
                emit_c = e;
                e = !e;
            end
            else
            begin
                // A kept backslash goes out ahead of the escaped byte.
                emit_bs = e && !((in_char == qat_pkg::CharSp) && (q == qat_pkg::QuoteNone));
                e = 1'b0;
                emit_c = 1'b1;
            end

            state_nxt.quote_kind = q;
            state_nxt.escape_pending = e;

            if (emit_bs)
            begin
                res0.out_char = qat_pkg::CharBs;
                res0.has_char = 1'b1;
                res1.out_char = in_char;
                res1.has_char = 1'b1;
                res1.last = 1'b1;
                res_count = 2'd2;
            end
            else if (emit_c)
            begin
                res0.out_char = in_char;
                res0.has_char = 1'b1;
                res0.last = 1'b1;
                res_count = 2'd1;
            end
        end
    end

endmodule

/* rtl/qat_res_fifo.sv */
module qat_res_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     push_n,
    input  qat_pkg::result_t               push0,
    input  qat_pkg::result_t               push1,
    input  logic                           pop,
    output qat_pkg::result_t               head,
    output logic                           not_empty,
    output logic [qat_pkg::ResCntW-1:0]    count
);

    qat_pkg::result_t mem [qat_pkg::ResDepth];

    logic [qat_pkg::ResPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [qat_pkg::ResPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [qat_pkg::ResCntW-1:0] count_reg, count_next;
    logic [qat_pkg::ResPtrW-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + qat_pkg::ResPtrW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + qat_pkg::ResPtrW'(pop);
    assign count_next = count_reg + qat_pkg::ResCntW'(push_n) - qat_pkg::ResCntW'(pop);

    assign head = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/quoted_argument_tokenizer.sv */
// Shell-style argument tokenizer.
// Input channel (in_valid/in_ready) takes one byte per request, or an
// end-of-input mark with in_end. Output channel (out_valid/out_ready)
// streams token characters (has_char) and end-of-token markers (token_end);
// last flags the final result caused by one input request.
// A request is registered on acceptance and decoded once the queue has room;
// its zero, one or two results then enter a four-entry result queue, whose
// head is offered on the output. Throughput is one request per cycle unless
// stalled. An escaped ordinary byte yields two results, but the backslash
// request before it yields none, so with the receiver always ready the queue
// never fills and in_ready stays high.
// The decode stage advances only when the queue has room for two results.
// When the receiver stalls, out_valid and the payload hold, the queue fills,
// and in_ready drops once the held request cannot be decoded.
// Reset clears the token state (between tokens, no quote, no escape), empties
// the queue and drops the held request.
module quoted_argument_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       token_end,
    output logic       last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       end_reg;

    qat_pkg::tok_state_t state_reg, state_next, state_dec;
    qat_pkg::result_t    res0, res1, head;
    logic [1:0]          res_count;
    logic [1:0]          push_n;
    logic                pop;
    logic                not_empty;
    logic                room;
    logic                step;
    logic                accept;
    logic [qat_pkg::ResCntW-1:0] count;

    qat_decode u_decode (
        .in_char   (char_reg),
        .in_end    (end_reg),
        .state_cur (state_reg),
        .state_nxt (state_dec),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    qat_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (count)
    );

    assign pop = not_empty && out_ready;
    assign room = (count - qat_pkg::ResCntW'(pop)) <= qat_pkg::ResCntW'(qat_pkg::ResDepth - 2);
    assign step = in_valid_reg && room;
    assign push_n = step ? res_count : 2'd0;
    assign in_ready = !in_valid_reg || step;
    assign accept = in_valid && in_ready;
    assign in_valid_next = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign state_next = step ? state_dec : state_reg;

    assign out_valid = not_empty;
    assign out_char = head.out_char;
    assign has_char = head.has_char;
    assign token_end = head.token_end;
    assign last = head.last;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= in_char;
            end_reg <= in_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg <= state_next;
        end
    end

    // Quote and escape state are always clear between tokens.
    a_clear_between: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.in_token |-> (state_reg.quote_kind == qat_pkg::QuoteNone) &&
                                !state_reg.escape_pending)
        else $error("quote or escape state set between tokens");

    a_quote_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.quote_kind != 2'd3)
        else $error("invalid quote code");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= qat_pkg::ResCntW'(qat_pkg::ResDepth))
        else $error("result queue overflow");

    a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_end |-> !has_char && last)
        else $error("end-of-token result carries a character");

endmodule

/* dv/tb_quoted_argument_tokenizer.sv */
`timescale 1ns / 100ps

module tb_quoted_argument_tokenizer;

    localparam int CycleLimit = 200000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_char;
    logic       in_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       token_end;
    logic       last;

    // Predictor state for the token currently being scanned.
    logic       tok_open;
    logic [1:0] quote_open;
    logic       escape_armed;

    qat_pkg::result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      quiet_left = 0;
    logic    calm = 1'b0;

    quoted_argument_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .in_end    (in_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .has_char  (has_char),
        .token_end (token_end),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("tb_quoted_argument_tokenizer failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic qat_pkg::result_t char_result(input logic [7:0] c);
        qat_pkg::result_t r;
        r.out_char  = c;
        r.has_char  = 1'b1;
        r.token_end = 1'b0;
        r.last      = 1'b0;
        return r;
    endfunction

    task automatic tokenize_byte(input logic [7:0] c, input logic e);
        qat_pkg::result_t made[$];
        qat_pkg::result_t r;
        logic [1:0] q;
        logic       blank;
        blank = (c == qat_pkg::CharTab) || (c == qat_pkg::CharLf) || (c == qat_pkg::CharCr);
        if (!tok_open)
        begin
            if (e || blank || c == qat_pkg::CharSp)
                return;
            tok_open     = 1'b1;
            quote_open   = qat_pkg::QuoteNone;
            escape_armed = 1'b0;
        end
        else if (e || blank ||
                 (c == qat_pkg::CharSp && quote_open == qat_pkg::QuoteNone && !escape_armed))
        begin
            r.out_char  = 8'h00;
            r.has_char  = 1'b0;
            r.token_end = 1'b1;
            r.last      = 1'b1;
            pending_results.push_back(r);
            tok_open     = 1'b0;
            quote_open   = qat_pkg::QuoteNone;
            escape_armed = 1'b0;
            return;
        end

        if (c == qat_pkg::CharDq || c == qat_pkg::CharSq)
        begin
            q = (c == qat_pkg::CharDq) ? qat_pkg::QuoteDouble : qat_pkg::QuoteSingle;
            if (quote_open == q)
            begin
                if (escape_armed)
                begin
                    made.push_back(char_result(c));
                    escape_armed = 1'b0;
                end
                else
                    quote_open = qat_pkg::QuoteNone;
            end
            else if (quote_open == qat_pkg::QuoteNone && !escape_armed)
                quote_open = q;
            else
            begin
                escape_armed = 1'b0;
                made.push_back(char_result(c));
            end
        end
        else if (c == qat_pkg::CharBs)
        begin
            if (escape_armed)
            begin
                made.push_back(char_result(c));
                escape_armed = 1'b0;
            end
            else
                escape_armed = 1'b1;
        end
        else
        begin
            // An escaped space outside quotes loses its backslash; any other
            // escaped ordinary byte keeps it.
            if (escape_armed)
            begin
                if (!(c == qat_pkg::CharSp && quote_open == qat_pkg::QuoteNone))
                    made.push_back(char_result(qat_pkg::CharBs));
                escape_armed = 1'b0;
            end
            made.push_back(char_result(c));
        end

        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            pending_results.push_back(made[i]);
    endtask

    task automatic check_result();
        qat_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result char=%02h has=%0b end=%0b last=%0b not expected",
                                      out_char, has_char, token_end, last));
            return;
        end
        want = pending_results.pop_front();
        if (out_char !== want.out_char)
            report_mismatch($sformatf("out_char %02h, expected %02h", out_char, want.out_char));
        if (has_char !== want.has_char)
            report_mismatch($sformatf("has_char %0b, expected %0b", has_char, want.has_char));
        if (token_end !== want.token_end)
            report_mismatch($sformatf("token_end %0b, expected %0b", token_end, want.token_end));
        if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tokenize_byte(in_char, in_end);
            if (out_valid && out_ready)
                check_result();
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
                out_ready <= 1'b1;
            else if (quiet_left == 0 && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Entered at a clock edge; returns at the edge where the request was taken.
    task automatic send_request(input logic [7:0] c, input logic e);
        if (!calm)
        begin
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 39) == 0)
                quiet_left = $urandom_range(15, 50);
            else if ($urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_end   <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        unique case ($urandom_range(0, 5))
            0: return qat_pkg::CharTab;
            1: return qat_pkg::CharLf;
            2: return qat_pkg::CharCr;
            default: return qat_pkg::CharSp;
        endcase
    endfunction

    function automatic logic [7:0] pick_token_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 55)
            return 8'($urandom_range(0, 255));
        else if (r < 65)
            return qat_pkg::CharDq;
        else if (r < 73)
            return qat_pkg::CharSq;
        else if (r < 85)
            return qat_pkg::CharBs;
        else if (r < 95)
            return qat_pkg::CharSp;
        else
            return pick_blank();
    endfunction

    task automatic send_line();
        int n_tok;
        int len;
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_request(pick_token_byte(), 1'b0);
            repeat ($urandom_range(1, 2))
                send_request(pick_blank(), 1'b0);
        end
        if ($urandom_range(0, 9) < 3)
            send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_request(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_blank_skipping();
        send_request(8'hFF, 1'b1);
        send_request(qat_pkg::CharSp, 1'b0);
        send_request(qat_pkg::CharLf, 1'b0);
        send_request(qat_pkg::CharCr, 1'b0);
    endtask

    task automatic test_plain_token();
        send_request(8'h61, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(qat_pkg::CharTab, 1'b0);
    endtask

    task automatic test_quoting();
        send_request(qat_pkg::CharDq, 1'b0);
        send_request(qat_pkg::CharSp, 1'b0);
        send_request(qat_pkg::CharSq, 1'b0);
        send_request(qat_pkg::CharDq, 1'b0);
        send_request(qat_pkg::CharLf, 1'b0);
        // A token that ends with its quote still open.
        send_request(qat_pkg::CharSq, 1'b0);
        send_request(qat_pkg::CharCr, 1'b0);
    endtask

    task automatic test_escapes();
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(8'h61, 1'b0);
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(qat_pkg::CharSp, 1'b0);
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(qat_pkg::CharDq, 1'b0);
        send_request(qat_pkg::CharSp, 1'b0);
        // The dangling backslash is dropped when input ends.
        send_request(qat_pkg::CharBs, 1'b0);
        send_request(8'h00, 1'b1);
    endtask

    task automatic test_random_stream(input int n_lines);
        for (int i = 0; i < n_lines; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_line();
            else
                send_noise();
        end
    endtask

    task automatic test_pause_drain();
        for (int k = 0; k < 3; k++)
        begin
            send_line();
            wait_for_drain();
        end
    endtask

    task automatic test_calm_stream();
        calm = 1'b1;
        test_random_stream(12);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_char  <= 8'h00;
        in_end   <= 1'b0;
        tok_open     = 1'b0;
        quote_open   = qat_pkg::QuoteNone;
        escape_armed = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blank_skipping();
        test_plain_token();
        test_quoting();
        test_escapes();
        test_random_stream(24);
        test_pause_drain();
        test_random_stream(8);
        test_calm_stream();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_quoted_argument_tokenizer passed");
        else
            $display("tb_quoted_argument_tokenizer failed");
        $finish;
    end

endmodule
